// File: src/dlts_pkg.sv
// types and constants shared by the delta list task scheduler
`timescale 1ns / 1ps
package dlts_pkg;

   localparam int TaskWidth    = 8;
   localparam int DeltaWidth   = 32;
   localparam int PendWidth    = 8;
   localparam int FuncWidth    = 2;
   localparam int SlotWidth    = 4;
   localparam int CountWidth   = 5;
   localparam int ReqDataWidth = 72;
   localparam int RspDataWidth = 24;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_TICK     = 2'd0,
      FUNC_ADD      = 2'd1,
      FUNC_DISPATCH = 2'd2,
      FUNC_NONE     = 2'd3
   } func_type;

   typedef struct packed {
      logic [PendWidth-1:0]  pending;
      logic [DeltaWidth-1:0] period;
      logic [DeltaWidth-1:0] delta;
      logic [TaskWidth-1:0]  task_id;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_WR,
      ST_ADD_RD,
      ST_ADD_CHK,
      ST_SHF_RD,
      ST_SHF_WR,
      ST_NEW_WR,
      ST_DSP_CHK,
      ST_RMV_RD,
      ST_RMV_WR,
      ST_DONE
   } state_type;

endpackage

// File: src/delta_list_task_scheduler_unit.sv
// delta list task scheduler: sorted timer list held in one entry memory
//
//  channel | ports          | word contents
//  --------+----------------+-------------------------------------------------
//  request | req_t*         | tuser: func; tdata: task_id, delay, period
//  result  | rsp_t*         | tdata: run_valid, run_task, add_full, add_slot,
//          |                |        task_count
//
// one word at a time; a tick updates the head entry before output, an add walks
// the entries passed and then moves later entries up by one, a dispatch shifts
// the remaining entries down by one, plus the add walk again for a periodic
// task.
// the entry memory has one read and one write port with registered read data.
// synchronous reset clears the entry count and control; the memory is not cleared.
// a finished result waits in the output register while the next word is taken.
`timescale 1ns / 1ps
module delta_list_task_scheduler_unit #(
   parameter int MAX_TASKS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] task_id, [39:8] delay, [71:40] period
   input  logic [dlts_pkg::ReqDataWidth-1:0]  req_tdata,
   // [1:0] func
   input  logic [dlts_pkg::FuncWidth-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] run_valid, [8:1] run_task, [9] add_full, [13:10] add_slot,
   // [18:14] task_count, [23:19] zero
   output logic [dlts_pkg::RspDataWidth-1:0]  rsp_tdata
);
   import dlts_pkg::*;

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   entry_type mem [MAX_TASKS];
   entry_type rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic          wr_en;
   entry_type     wr_data;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] k_ff, k_in;
   logic [TaskWidth-1:0]  id_ff, id_in;
   logic [DeltaWidth-1:0] dly_ff, dly_in;
   logic [DeltaWidth-1:0] per_ff, per_in;
   logic report_ff, report_in;
   logic res_run_ff, res_run_in;
   logic [TaskWidth-1:0] res_task_ff, res_task_in;
   logic res_full_ff, res_full_in;
   logic [SlotWidth-1:0] res_slot_ff, res_slot_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;
   func_type req_func;

   assign req_func   = func_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      id_ff       <= id_in;
      dly_ff      <= dly_in;
      per_ff      <= per_in;
      report_ff   <= report_in;
      res_run_ff  <= res_run_in;
      res_task_ff <= res_task_in;
      res_full_ff <= res_full_in;
      res_slot_ff <= res_slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      id_in        = id_ff;
      dly_in       = dly_ff;
      per_in       = per_ff;
      report_in    = report_ff;
      res_run_in   = res_run_ff;
      res_task_in  = res_task_ff;
      res_full_in  = res_full_ff;
      res_slot_in  = res_slot_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rd_addr      = '0;
      wr_addr      = '0;
      wr_en        = 1'b0;
      wr_data      = rd_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               id_in       = req_tdata[7:0];
               dly_in      = req_tdata[39:8];
               per_in      = req_tdata[71:40];
               pos_in      = '0;
               report_in   = 1'b1;
               res_run_in  = 1'b0;
               res_task_in = '0;
               res_full_in = 1'b0;
               res_slot_in = '0;
               state_in    = ST_DONE;
               case (req_func)
                  FUNC_TICK: begin
                     if (cnt_ff != '0) begin
                        state_in = ST_TICK_WR;
                     end
                  end
                  FUNC_ADD: begin
                     if (cnt_ff == CW'(MAX_TASKS)) begin
                        res_full_in = 1'b1;
                     end else begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  FUNC_DISPATCH: begin
                     if (cnt_ff != '0) begin
                        state_in = ST_DSP_CHK;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_TICK_WR: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            if (rd_data_ff.delta == '0) begin
               wr_data.pending = rd_data_ff.pending + PendWidth'(1);
            end else begin
               wr_data.delta = rd_data_ff.delta - DeltaWidth'(1);
            end
            state_in = ST_DONE;
         end
         ST_ADD_RD: begin
            rd_addr = pos_ff[IW-1:0];
            if (pos_ff == cnt_ff) begin
               k_in     = cnt_ff;
               state_in = ST_SHF_RD;
            end else begin
               state_in = ST_ADD_CHK;
            end
         end
         ST_ADD_CHK: begin
            if (dly_ff >= rd_data_ff.delta) begin
               dly_in   = dly_ff - rd_data_ff.delta;
               pos_in   = pos_ff + CW'(1);
               state_in = ST_ADD_RD;
            end else begin
               k_in     = cnt_ff;
               state_in = ST_SHF_RD;
            end
         end
         ST_SHF_RD: begin
            if (k_ff == pos_ff) begin
               state_in = ST_NEW_WR;
            end else begin
               rd_addr  = IW'(k_ff - CW'(1));
               state_in = ST_SHF_WR;
            end
         end
         ST_SHF_WR: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[IW-1:0];
            if (k_ff == pos_ff + CW'(1)) begin
               wr_data.delta = rd_data_ff.delta - dly_ff;
            end
            k_in     = k_ff - CW'(1);
            state_in = ST_SHF_RD;
         end
         ST_NEW_WR: begin
            wr_en           = 1'b1;
            wr_addr         = pos_ff[IW-1:0];
            wr_data.task_id = id_ff;
            wr_data.delta   = dly_ff;
            wr_data.period  = per_ff;
            wr_data.pending = '0;
            cnt_in          = cnt_ff + CW'(1);
            if (report_ff) begin
               res_slot_in = SlotWidth'(pos_ff);
            end
            state_in = ST_DONE;
         end
         ST_DSP_CHK: begin
            if (rd_data_ff.pending == '0) begin
               state_in = ST_DONE;
            end else begin
               res_run_in  = 1'b1;
               res_task_in = rd_data_ff.task_id;
               id_in       = rd_data_ff.task_id;
               per_in      = rd_data_ff.period;
               dly_in      = rd_data_ff.period;
               k_in        = '0;
               state_in    = ST_RMV_RD;
            end
         end
         ST_RMV_RD: begin
            if (k_ff + CW'(1) >= cnt_ff) begin
               cnt_in = cnt_ff - CW'(1);
               if (per_ff != '0) begin
                  pos_in    = '0;
                  report_in = 1'b0;
                  state_in  = ST_ADD_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               rd_addr  = IW'(k_ff + CW'(1));
               state_in = ST_RMV_WR;
            end
         end
         ST_RMV_WR: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff[IW-1:0];
            k_in     = k_ff + CW'(1);
            state_in = ST_RMV_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, CountWidth'(cnt_ff), res_slot_ff, res_full_ff,
                               res_task_ff, res_run_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
